// File: hdl/wave_leapfrog_stencil_3d_top_defines.svh
// assertion macros shared by the stencil block
// no dependencies
`ifndef WAVE_LEAPFROG_STENCIL_3D_TOP_DEFINES_SVH
`define WAVE_LEAPFROG_STENCIL_3D_TOP_DEFINES_SVH
`define WLS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wls assertion failed");
`define WLS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wls assertion failed");
`endif

// File: hdl/wls_pkg.sv
// types and constants of the 3-d wave stencil block
// no dependencies
package wls_pkg;

    localparam int Q_DEPTH = 4;
    localparam int QCW     = 3;
    localparam int ACC_W   = 56;

    localparam logic [2:0] CFG_COEF_X = 3'd0;
    localparam logic [2:0] CFG_COEF_Y = 3'd1;
    localparam logic [2:0] CFG_COEF_Z = 3'd2;
    localparam logic [2:0] CFG_SIZE_X = 3'd3;
    localparam logic [2:0] CFG_SIZE_Y = 3'd4;
    localparam logic [2:0] CFG_SIZE_Z = 3'd5;

    typedef struct packed {
        logic signed [31:0] cur_value;
        logic signed [31:0] old_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_value;
        logic [6:0]         pos_x;
        logic [6:0]         pos_y;
        logic [11:0]        pos_z;
        logic               last_point;
    } t_out;

    typedef struct packed {
        logic [15:0] coef_x;
        logic [15:0] coef_y;
        logic [15:0] coef_z;
        logic [7:0]  size_x;
        logic [7:0]  size_y;
        logic [12:0] size_z;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  pos_x;
        logic [6:0]  pos_y;
        logic [11:0] pos_z;
        logic        last_point;
    } t_meta;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] xm;
        logic signed [31:0] xp;
        logic signed [31:0] ym;
        logic signed [31:0] yp;
        logic signed [31:0] below;
        logic signed [31:0] above;
        logic signed [31:0] old;
        t_meta              meta;
    } t_job;

endpackage

// File: hdl/wls_front.sv
// front end: raster counters, plane memories, interior test
// depends on wls_pkg and the assertion macro header
`include "wave_leapfrog_stencil_3d_top_defines.svh"
module wls_front #(
    parameter int MAX_NX = 128,
    parameter int MAX_NY = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wls_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  wls_pkg::t_in      i_data,
    output logic              o_ready,
    input  logic [wls_pkg::QCW-1:0] i_free,
    output logic              o_push,
    output wls_pkg::t_job     o_job
);
    import wls_pkg::*;

    localparam int XW    = $clog2(MAX_NX);
    localparam int YW    = $clog2(MAX_NY);
    localparam int XS    = XW + 2;
    localparam int YS    = YW + 2;
    localparam int ZS    = 14;
    localparam int DEPTH = MAX_NX * MAX_NY;
    localparam int AW    = $clog2(DEPTH);

    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic [11:0]   r_z, n_z;
    logic          r_clearing;
    logic [AW-1:0] r_clr;

    logic [XS-1:0] w_sx, w_xe, w_nx;
    logic [YS-1:0] w_sy, w_ye, w_ny;
    logic [ZS-1:0] w_sz, w_ze, w_nz;
    logic          w_acc, w_interior, w_last;
    logic [AW-1:0] w_here, w_xm, w_xp, w_ym, w_yp, w_wa;
    logic [31:0]   w_wd;

    logic [4:0][31:0] w_rd [2];
    logic [31:0]   r_old_mem [DEPTH];
    logic [31:0]   r_old_q;

    logic          r_s1_valid;
    logic          r_s1_par;
    logic [31:0]   r_s1_cur;
    t_meta         r_s1_meta;

    assign o_ready = !r_clearing && (i_free > QCW'(r_s1_valid));
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        if (i_cfg.size_x < 8'd3) begin
            w_sx = XS'(3);
        end else if (int'(i_cfg.size_x) > MAX_NX) begin
            w_sx = XS'(MAX_NX);
        end else begin
            w_sx = XS'(i_cfg.size_x);
        end
        if (i_cfg.size_y < 8'd3) begin
            w_sy = YS'(3);
        end else if (int'(i_cfg.size_y) > MAX_NY) begin
            w_sy = YS'(MAX_NY);
        end else begin
            w_sy = YS'(i_cfg.size_y);
        end
        if (i_cfg.size_z < 13'd3) begin
            w_sz = ZS'(3);
        end else if (i_cfg.size_z > 13'd4096) begin
            w_sz = ZS'(4096);
        end else begin
            w_sz = ZS'(i_cfg.size_z);
        end
    end

    assign w_xe = XS'(r_x);
    assign w_ye = YS'(r_y);
    assign w_ze = ZS'(r_z);

    assign w_interior = (r_x != '0) && (w_xe + XS'(2) <= w_sx)
                     && (r_y != '0) && (w_ye + YS'(2) <= w_sy)
                     && (r_z >= 12'd2) && (w_ze + ZS'(1) <= w_sz);
    assign w_last = (w_xe + XS'(2) == w_sx) && (w_ye + YS'(2) == w_sy)
                 && (w_ze + ZS'(1) == w_sz);

    // raster advance, x fastest
    always_comb begin
        w_nx = w_xe + XS'(1);
        w_ny = w_ye + YS'(1);
        w_nz = w_ze + ZS'(1);
        n_x  = r_x;
        n_y  = r_y;
        n_z  = r_z;
        if (w_acc) begin
            if (w_nx >= w_sx) begin
                n_x = '0;
                if (w_ny >= w_sy) begin
                    n_y = '0;
                    if (w_nz >= w_sz) begin
                        n_z = '0;
                    end else begin
                        n_z = 12'(w_nz);
                    end
                end else begin
                    n_y = YW'(w_ny);
                end
            end else begin
                n_x = XW'(w_nx);
            end
        end
    end

    assign w_here = AW'(int'(r_y) * MAX_NX + int'(r_x));
    assign w_xm   = w_here - AW'(1);
    assign w_xp   = w_here + AW'(1);
    assign w_ym   = AW'(int'(w_here) - MAX_NX);
    assign w_yp   = AW'(int'(w_here) + MAX_NX);
    assign w_wa   = r_clearing ? r_clr : w_here;
    assign w_wd   = r_clearing ? 32'd0 : i_data.cur_value;

    // two current planes, by parity of z, three copies each for the read ports
    for (genvar b = 0; b < 2; b++) begin : g_bank
        logic [31:0] r_m0 [DEPTH];
        logic [31:0] r_m1 [DEPTH];
        logic [31:0] r_m2 [DEPTH];
        logic [31:0] r_q0, r_q1, r_q2, r_q3, r_q4;
        logic        w_we;

        assign w_we = r_clearing || (w_acc && (r_z[0] == 1'(b)));

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_m0[w_wa] <= w_wd;
            end
            if (w_acc) begin
                r_q0 <= r_m0[w_here];
                r_q1 <= r_m0[w_xm];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_m1[w_wa] <= w_wd;
            end
            if (w_acc) begin
                r_q2 <= r_m1[w_xp];
                r_q3 <= r_m1[w_ym];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_m2[w_wa] <= w_wd;
            end
            if (w_acc) begin
                r_q4 <= r_m2[w_yp];
            end
        end

        assign w_rd[b] = {r_q4, r_q3, r_q2, r_q1, r_q0};
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing || w_acc) begin
            r_old_mem[w_wa] <= r_clearing ? 32'd0 : i_data.old_value;
        end
        if (w_acc) begin
            r_old_q <= r_old_mem[w_here];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_y        <= '0;
            r_z        <= '0;
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_x        <= n_x;
            r_y        <= n_y;
            r_z        <= n_z;
            r_s1_valid <= w_acc && w_interior;
            if (r_clearing) begin
                r_clr <= r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_par             <= r_z[0];
            r_s1_cur             <= i_data.cur_value;
            r_s1_meta.pos_x      <= 7'(r_x);
            r_s1_meta.pos_y      <= 7'(r_y);
            r_s1_meta.pos_z      <= r_z - 12'd1;
            r_s1_meta.last_point <= w_last;
        end
    end

    assign o_push      = r_s1_valid;
    assign o_job.c     = w_rd[~r_s1_par][0];
    assign o_job.xm    = w_rd[~r_s1_par][1];
    assign o_job.xp    = w_rd[~r_s1_par][2];
    assign o_job.ym    = w_rd[~r_s1_par][3];
    assign o_job.yp    = w_rd[~r_s1_par][4];
    assign o_job.below = w_rd[r_s1_par][0];
    assign o_job.above = r_s1_cur;
    assign o_job.old   = r_old_q;
    assign o_job.meta  = r_s1_meta;

    `WLS_ASSERT_IMP(a_no_accept_clearing, i_clk, i_rst_n, r_clearing, !o_ready)
    `WLS_ASSERT_NXT(a_interior_pushes, i_clk, i_rst_n, w_acc && w_interior, r_s1_valid)
    `WLS_ASSERT_IMP(a_push_has_room, i_clk, i_rst_n, r_s1_valid, i_free != '0)

endmodule

// File: hdl/wls_fifo.sv
// short queue of stencil jobs between front and back end
// depends on wls_pkg and the assertion macro header
`include "wave_leapfrog_stencil_3d_top_defines.svh"
module wls_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wls_pkg::t_job     i_job,
    input  logic              i_pop,
    output logic              o_valid,
    output wls_pkg::t_job     o_job,
    output logic [wls_pkg::QCW-1:0] o_free
);
    import wls_pkg::*;

    t_job           r_mem [Q_DEPTH];
    logic [1:0]     r_wp, r_rp;
    logic [QCW-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign o_free  = QCW'(Q_DEPTH) - r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(i_pop);
        end
    end

    `WLS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt != QCW'(Q_DEPTH))
    `WLS_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_cnt != '0)
    `WLS_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + QCW'(1))

endmodule

// File: hdl/wls_back.sv
// back end: differences, coefficient products, rounding and saturation
// depends on wls_pkg
module wls_back #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wls_pkg::t_cfg     i_cfg,
    input  logic              i_job_valid,
    input  wls_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    output wls_pkg::t_out     o_data,
    input  logic              i_ready
);
    import wls_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;

    logic signed [33:0] r_dxx, r_dyy, r_dzz, r_base;
    logic signed [50:0] r_px, r_py, r_pz, r_bsh;
    logic signed [ACC_W-1:0] r_acc;
    t_meta r_m1, r_m2, r_m3;
    t_out  r_out;

    logic signed [33:0] w_c2;
    logic signed [ACC_W-1:0] w_r;

    assign w_adv4 = !r_v4 || i_ready;
    assign w_adv3 = !r_v3 || w_adv4;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_pop  = i_job_valid && w_adv1;

    assign w_c2 = 34'(i_job.c) <<< 1;
    assign w_r  = r_acc >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_job_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
            if (w_adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dxx  <= 34'(i_job.xm) - w_c2 + 34'(i_job.xp);
            r_dyy  <= 34'(i_job.ym) - w_c2 + 34'(i_job.yp);
            r_dzz  <= 34'(i_job.below) - w_c2 + 34'(i_job.above);
            r_base <= w_c2 - 34'(i_job.old);
            r_m1   <= i_job.meta;
        end
        if (w_adv2 && r_v1) begin
            r_px  <= $signed({1'b0, i_cfg.coef_x}) * r_dxx;
            r_py  <= $signed({1'b0, i_cfg.coef_y}) * r_dyy;
            r_pz  <= $signed({1'b0, i_cfg.coef_z}) * r_dzz;
            r_bsh <= 51'(r_base) <<< 16;
            r_m2  <= r_m1;
        end
        if (w_adv3 && r_v2) begin
            r_acc <= ACC_W'(r_px) + ACC_W'(r_py) + ACC_W'(r_pz) + ACC_W'(r_bsh)
                   + ACC_W'(32768);
            r_m3  <= r_m2;
        end
        if (w_adv4 && r_v3) begin
            // round half up, then saturate
            if (w_r > SAT_HI) begin
                r_out.new_value <= SAT_HI[31:0];
            end else if (w_r < SAT_LO) begin
                r_out.new_value <= SAT_LO[31:0];
            end else begin
                r_out.new_value <= w_r[31:0];
            end
            r_out.pos_x      <= r_m3.pos_x;
            r_out.pos_y      <= r_m3.pos_y;
            r_out.pos_z      <= r_m3.pos_z;
            r_out.last_point <= r_m3.last_point;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_out;

endmodule

// File: hdl/wave_leapfrog_stencil_3d_top.sv
// channel   dir  signals
// input     in   i_valid, o_ready, i_data (cur_value, old_value)
// result    out  o_valid, i_ready, o_data (new_value, pos_x/y/z, last_point)
// config    in   i_cfg_we, i_cfg_idx, i_cfg_data
// one point accepted per cycle while o_ready is high
// after reset the plane memories are swept to zero, all MAX_NX*MAX_NY entries (16384),
// with o_ready low; boundary points give no result
// the 4-entry job queue lets input run on while o_data stalls, until it fills
// top level of the 3-d wave stencil; depends on wls_pkg, wls_front, wls_fifo, wls_back
module wave_leapfrog_stencil_3d_top #(
    parameter int MAX_NX      = 128,
    parameter int MAX_NY      = 128,
    parameter int SAMPLE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wls_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output wls_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);
    import wls_pkg::*;

    t_cfg           r_cfg;
    logic           w_push, w_qvalid, w_pop;
    t_job           w_push_job, w_qjob;
    logic [QCW-1:0] w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_x <= 16'd10486;
            r_cfg.coef_y <= 16'd10486;
            r_cfg.coef_z <= 16'd10486;
            r_cfg.size_x <= 8'd128;
            r_cfg.size_y <= 8'd128;
            r_cfg.size_z <= 13'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COEF_X: r_cfg.coef_x <= i_cfg_data;
                CFG_COEF_Y: r_cfg.coef_y <= i_cfg_data;
                CFG_COEF_Z: r_cfg.coef_z <= i_cfg_data;
                CFG_SIZE_X: r_cfg.size_x <= i_cfg_data[7:0];
                CFG_SIZE_Y: r_cfg.size_y <= i_cfg_data[7:0];
                CFG_SIZE_Z: r_cfg.size_z <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    wls_front #(
        .MAX_NX (MAX_NX),
        .MAX_NY (MAX_NY)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (o_ready),
        .i_free  (w_free),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    wls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_qjob),
        .o_free  (w_free)
    );

    wls_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_qvalid),
        .i_job       (w_qjob),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_ready     (i_ready)
    );

endmodule

// File: sim/wave_leapfrog_stencil_3d_top_tb.sv
// self-checking testbench for the 3-d wave leapfrog stencil: directed grid, random and calm phases
// checks each result word vs an in-bench stencil predictor or typed row; random idling unless calm
// depends on wls_pkg and wave_leapfrog_stencil_3d_top
module wave_leapfrog_stencil_3d_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wls_pkg::*;

    localparam int PLANE   = 128 * 128;
    localparam int LIMIT   = 1000000;
    localparam int N_PHASE = 10;

    typedef struct {
        t_in  word;
        bit   typed;
        t_out want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    logic [15:0] coef_x_q, coef_y_q, coef_z_q;
    logic [7:0]  size_x_q, size_y_q;
    logic [12:0] size_z_q;
    logic signed [31:0] cur_plane_mem [0:2*PLANE-1];
    logic signed [31:0] old_plane_mem [0:PLANE-1];
    int unsigned col_q, row_q, plane_q;

    t_out pending_points[$];
    t_row grid_rows[$];
    bit   calm;
    int   fail_count;
    int   words_sent;
    int   points_seen;
    int   cycles;

    wave_leapfrog_stencil_3d_top DUT (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic bit leapfrog_point(input t_in w, output t_out r);
        int unsigned sx, sy, sz, x, y, z;
        int here, now_b, prev_b;
        longint c, cur, dxx, dyy, dzz, acc, res;
        bit hit;
        sx = size_x_q < 3 ? 3 : (size_x_q > 128 ? 128 : size_x_q);
        sy = size_y_q < 3 ? 3 : (size_y_q > 128 ? 128 : size_y_q);
        sz = size_z_q < 3 ? 3 : (size_z_q > 4096 ? 4096 : size_z_q);
        x = col_q;
        y = row_q;
        z = plane_q;
        here = (y % 128) * 128 + (x % 128);
        now_b = (z & 1) * PLANE;
        prev_b = ((z + 1) & 1) * PLANE;
        cur = w.cur_value;
        hit = x >= 1 && x + 2 <= sx && y >= 1 && y + 2 <= sy && z >= 2 && z + 1 <= sz;
        r = '0;
        if (hit) begin
            c = cur_plane_mem[prev_b + here];
            dxx = longint'(cur_plane_mem[prev_b + here - 1]) - 2 * c
                + longint'(cur_plane_mem[prev_b + here + 1]);
            dyy = longint'(cur_plane_mem[prev_b + here - 128]) - 2 * c
                + longint'(cur_plane_mem[prev_b + here + 128]);
            dzz = longint'(cur_plane_mem[now_b + here]) - 2 * c + cur;
            acc = (2 * c - longint'(old_plane_mem[here])) * 65536;
            acc += longint'({1'b0, coef_x_q}) * dxx;
            acc += longint'({1'b0, coef_y_q}) * dyy;
            acc += longint'({1'b0, coef_z_q}) * dzz;
            res = (acc + 32768) >>> 16;
            if (res > 64'sh7FFFFFFF) res = 64'sh7FFFFFFF;
            if (res < -64'sh80000000) res = -64'sh80000000;
            r.new_value = res[31:0];
            r.pos_x = x[6:0];
            r.pos_y = y[6:0];
            r.pos_z = 12'(z - 1);
            r.last_point = (x + 2 == sx && y + 2 == sy && z + 1 == sz);
        end
        cur_plane_mem[now_b + here] = w.cur_value;
        old_plane_mem[here] = w.old_value;
        x++;
        if (x >= sx) begin
            x = 0;
            y++;
            if (y >= sy) begin
                y = 0;
                z++;
                if (z >= sz) z = 0;
            end
        end
        col_q = x & 7'h7F;
        row_q = y & 7'h7F;
        plane_q = z & 12'hFFF;
        return hit;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_COEF_X: coef_x_q = val;
            CFG_COEF_Y: coef_y_q = val;
            CFG_COEF_Z: coef_z_q = val;
            CFG_SIZE_X: size_x_q = val[7:0];
            CFG_SIZE_Y: size_y_q = val[7:0];
            CFG_SIZE_Z: size_z_q = val[12:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic push_word(input t_row row);
        t_out r;
        bit hit;
        while (!calm && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= row.word;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        hit = leapfrog_point(row.word, r);
        if (row.typed) pending_points.push_back(row.want);
        else if (hit) pending_points.push_back(r);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample;
        if ($urandom_range(99) < 30) return $urandom;
        return 32'(int'($urandom_range(67108864)) - 33554432);
    endfunction

    function automatic logic [15:0] rand_coef;
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(20000));
        endcase
    endfunction

    function automatic logic [15:0] rand_size;
        case ($urandom_range(9))
            0: return 16'($urandom_range(2));
            1: return 16'd255;
            default: return 16'($urandom_range(3, 6));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            points_seen++;
            if (pending_points.size() == 0) begin
                $error("unexpected word: new_value %h", o_data.new_value);
                fail_count++;
            end else begin
                t_out e;
                e = pending_points.pop_front();
                if (o_data.new_value !== e.new_value) begin
                    $error("new_value expected %h actual %h", e.new_value, o_data.new_value);
                    fail_count++;
                end
                if (o_data.pos_x !== e.pos_x) begin
                    $error("pos_x expected %0d actual %0d", e.pos_x, o_data.pos_x);
                    fail_count++;
                end
                if (o_data.pos_y !== e.pos_y) begin
                    $error("pos_y expected %0d actual %0d", e.pos_y, o_data.pos_y);
                    fail_count++;
                end
                if (o_data.pos_z !== e.pos_z) begin
                    $error("pos_z expected %0d actual %0d", e.pos_z, o_data.pos_z);
                    fail_count++;
                end
                if (o_data.last_point !== e.last_point) begin
                    $error("last_point expected %0d actual %0d", e.last_point, o_data.last_point);
                    fail_count++;
                end
            end
        end
        i_ready <= calm || $urandom_range(99) >= 26;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_row row;
        int n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_COEF_X;
        i_cfg_data = '0;
        calm = 1'b0;
        fail_count = 0;
        words_sent = 0;
        points_seen = 0;
        cycles = 0;
        coef_x_q = 16'd10486;
        coef_y_q = 16'd10486;
        coef_z_q = 16'd10486;
        size_x_q = 8'd128;
        size_y_q = 8'd128;
        size_z_q = 13'd128;
        col_q = 0;
        row_q = 0;
        plane_q = 0;
        for (int k = 0; k < 2 * PLANE; k++) cur_plane_mem[k] = '0;
        for (int k = 0; k < PLANE; k++) old_plane_mem[k] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest grid, flat field at the extremes: the single interior point saturates high
        cfg_write(CFG_SIZE_X, 16'd3);
        cfg_write(CFG_SIZE_Y, 16'd3);
        cfg_write(CFG_SIZE_Z, 16'd3);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 27; k++) begin
            row.word.cur_value = 32'h7FFFFFFF;
            row.word.old_value = 32'h80000000;
            row.typed = (k == 22);
            row.want = '{new_value: 32'h7FFFFFFF, pos_x: 7'd1, pos_y: 7'd1,
                         pos_z: 12'd1, last_point: 1'b1};
            grid_rows.push_back(row);
        end
        foreach (grid_rows[k]) push_word(grid_rows[k]);
        drain();

        for (int p = 0; p <= N_PHASE; p++) begin
            calm = (p == N_PHASE);
            if (calm) begin
                cfg_write(CFG_COEF_X, 16'hFFFF);
                cfg_write(CFG_COEF_Y, 16'd0);
                cfg_write(CFG_COEF_Z, 16'hFFFF);
                cfg_write(CFG_SIZE_X, 16'd255);
                cfg_write(CFG_SIZE_Y, 16'd3);
                cfg_write(CFG_SIZE_Z, 16'd0);
                n = 900;
            end else begin
                cfg_write(CFG_COEF_X, rand_coef());
                cfg_write(CFG_COEF_Y, rand_coef());
                cfg_write(CFG_COEF_Z, rand_coef());
                cfg_write(CFG_SIZE_X, rand_size());
                cfg_write(CFG_SIZE_Y, rand_size());
                cfg_write(CFG_SIZE_Z, $urandom_range(9) == 0 ? 16'h1FFF : rand_size());
                n = $urandom_range(60, 120);
            end
            i_cfg_we <= 1'b0;
            for (int k = 0; k < n; k++) begin
                row.word.cur_value = rand_sample();
                row.word.old_value = rand_sample();
                row.typed = 1'b0;
                push_word(row);
            end
            drain();
        end

        $display("run covered %0d input words over %0d settings, %0d result words checked",
                 words_sent, N_PHASE + 2, points_seen);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hdl
hdl/wls_pkg.sv
hdl/wls_front.sv
hdl/wls_fifo.sv
hdl/wls_back.sv
hdl/wave_leapfrog_stencil_3d_top.sv
sim/wave_leapfrog_stencil_3d_top_tb.sv
